// File: sv/edt_pkg.sv
// Shared types and constants for the edit distance block.
package edt_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int QDEPTH      = 4;
  localparam int RESULT_CAP  = 64;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_REPLACE = 2'd1;
  localparam logic [1:0] KIND_DELETE  = 2'd2;
  localparam logic [1:0] KIND_INSERT  = 2'd3;

  localparam logic MODE_SOURCE = 1'b0;
  localparam logic MODE_TARGET = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] symbol;
    logic       has_symbol;
    logic       last;
  } item_t;

endpackage

// File: sv/edt_front.sv
// Front end: takes requests from the command port and drops those that do nothing.
module edt_front import edt_pkg::*; (
  input  logic       rst_n,
  input  logic       start,
  input  logic       q_full,
  input  logic       in_mode,
  input  logic [7:0] in_symbol,
  input  logic       in_has_symbol,
  input  logic       in_last,
  output logic       busy,
  output logic       push,
  output item_t      push_item
);

  logic accept;

  // A request with neither a byte nor an end mark changes nothing.
  assign busy      = q_full || !rst_n;
  assign accept    = start && !busy;
  assign push      = accept && (in_has_symbol || in_last);
  assign push_item = '{mode: in_mode, symbol: in_symbol,
                       has_symbol: in_has_symbol, last: in_last};

endmodule

// File: sv/edt_queue.sv
// Small first-in first-out queue between the front end and the back end.
module edt_queue import edt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output item_t head
);

  localparam int QAW = $clog2(QDEPTH);

  item_t            slot_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full  = cnt_r == (QAW+1)'(QDEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

// File: sv/edt_back.sv
// Back end: string stores, cost table fill, traceback and result output.
module edt_back import edt_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  item_t      head,
  output logic       pop,
  output logic       out_valid,
  output logic [1:0] out_op_kind,
  output logic [5:0] out_position,
  output logic [7:0] out_old_symbol,
  output logic [7:0] out_new_symbol,
  output logic [5:0] out_distance,
  output logic       out_final_res,
  output logic       out_overflow
);

  localparam int DIM = MAX_LEN + 1;
  localparam int IW  = $clog2(MAX_LEN + 1);
  localparam int SW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int AW  = $clog2(DIM * DIM);
  localparam int CW  = IW;
  localparam int KW  = $clog2(RESULT_CAP + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FRD  = 4'd1;
  localparam logic [3:0] S_FWR  = 4'd2;
  localparam logic [3:0] S_TB0  = 4'd3;
  localparam logic [3:0] S_TB1  = 4'd4;
  localparam logic [3:0] S_TB2  = 4'd5;
  localparam logic [3:0] S_TB3  = 4'd6;
  localparam logic [3:0] S_TAIL = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [7:0]    src_mem [MAX_LEN];
  logic [7:0]    tgt_mem [MAX_LEN];
  logic [CW-1:0] cost_mem [DIM*DIM];
  logic [7:0]    src_rd, tgt_rd;
  logic [CW-1:0] cost_rd;

  logic [3:0]    st_r, st_nxt;
  logic [IW-1:0] slen_r, slen_nxt, tlen_r, tlen_nxt;
  logic          sdone_r, sdone_nxt, ovf_r, ovf_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] left_r, left_nxt, diag_r, diag_nxt;
  logic [CW-1:0] here_r, here_nxt, dist_r, dist_nxt;
  logic [7:0]    a_r, a_nxt, b_r, b_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          pv_r, pv_nxt;
  logic [1:0]    pk_r, pk_nxt;
  logic [5:0]    pp_r, pp_nxt;
  logic [7:0]    po_r, po_nxt, pn_r, pn_nxt;

  logic          ov_r, ov_nxt, of_r, of_nxt;
  logic          oovf_r, oovf_nxt;
  logic [1:0]    ok_r, ok_nxt;
  logic [5:0]    opos_r, opos_nxt;
  logic [7:0]    oold_r, oold_nxt, onew_r, onew_nxt;

  logic [SW-1:0] src_addr, tgt_addr, src_waddr, tgt_waddr;
  logic          src_we, tgt_we, cost_we;
  logic [AW-1:0] cr_addr, cw_addr;
  logic [CW-1:0] cw_data;

  logic          prod;
  logic [1:0]    prod_kind;
  logic [5:0]    prod_pos;
  logic [7:0]    prod_old, prod_new;

  logic [CW-1:0] up_v, dg_v, lf_v, mn_v, cell_v, bnd_v;
  logic [IW-1:0] im1, jm1;

  assign im1 = i_r - 1'b1;
  assign jm1 = j_r - 1'b1;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    addr_of = AW'(r) * AW'(DIM) + AW'(c);
  endfunction

  // Read addresses follow the state; the read data is registered and arrives in the next cycle.
  always_comb begin
    src_addr = SW'(im1);
    tgt_addr = SW'(jm1);
    cr_addr  = addr_of(im1, j_r);
    unique case (st_r)
      S_TB0:   cr_addr = addr_of(i_r, j_r);
      S_TB1:   cr_addr = addr_of(im1, jm1);
      default: cr_addr = addr_of(im1, j_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[src_waddr] <= head.symbol;
    end
    src_rd <= src_mem[src_addr];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= head.symbol;
    end
    tgt_rd <= tgt_mem[tgt_addr];
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cw_addr] <= cw_data;
    end
    cost_rd <= cost_mem[cr_addr];
  end

  // Cell arithmetic during the fill; row and column zero are implied.
  always_comb begin
    up_v   = (i_r == IW'(1)) ? CW'(j_r) : cost_rd;
    dg_v   = (j_r == IW'(1)) ? CW'(im1) : diag_r;
    lf_v   = (j_r == IW'(1)) ? CW'(i_r) : left_r;
    mn_v   = (dg_v < up_v) ? dg_v : up_v;
    mn_v   = (mn_v < lf_v) ? mn_v : lf_v;
    cell_v = (src_rd == tgt_rd) ? dg_v : mn_v + 1'b1;
  end

  always_comb begin
    st_nxt    = st_r;
    slen_nxt  = slen_r;
    tlen_nxt  = tlen_r;
    sdone_nxt = sdone_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    left_nxt  = left_r;
    diag_nxt  = diag_r;
    here_nxt  = here_r;
    dist_nxt  = dist_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    pop       = 1'b0;
    src_we    = 1'b0;
    tgt_we    = 1'b0;
    src_waddr = SW'(slen_r);
    tgt_waddr = SW'(tlen_r);
    cost_we   = 1'b0;
    cw_addr   = addr_of(i_r, j_r);
    cw_data   = cell_v;
    prod      = 1'b0;
    prod_kind = KIND_NONE;
    prod_pos  = '0;
    prod_old  = '0;
    prod_new  = '0;
    bnd_v     = '0;
    unique case (st_r)
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.mode == MODE_SOURCE) begin
            if (!sdone_r) begin
              if (head.has_symbol) begin
                if (slen_r < IW'(MAX_LEN)) begin
                  src_we   = 1'b1;
                  slen_nxt = slen_r + 1'b1;
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
              if (head.last) begin
                sdone_nxt = 1'b1;
              end
            end
          end else begin
            if (head.has_symbol) begin
              if (tlen_r < IW'(MAX_LEN)) begin
                tgt_we   = 1'b1;
                tlen_nxt = tlen_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            if (head.last) begin
              if (slen_nxt != '0 && tlen_nxt != '0) begin
                i_nxt  = IW'(1);
                j_nxt  = IW'(1);
                st_nxt = S_FRD;
              end else begin
                dist_nxt = (slen_nxt == '0) ? CW'(tlen_nxt) : CW'(slen_nxt);
                i_nxt    = slen_nxt;
                j_nxt    = tlen_nxt;
                st_nxt   = S_TB0;
              end
            end
          end
        end
      end
      S_FRD: begin
        st_nxt = S_FWR;
      end
      S_FWR: begin
        cost_we  = 1'b1;
        left_nxt = cell_v;
        diag_nxt = up_v;
        st_nxt   = S_FRD;
        if (j_r == tlen_r) begin
          j_nxt = IW'(1);
          if (i_r == slen_r) begin
            dist_nxt = cell_v;
            i_nxt    = slen_r;
            j_nxt    = tlen_r;
            st_nxt   = S_TB0;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_TB0: begin
        if (i_r != '0 && j_r != '0) begin
          st_nxt = S_TB1;
        end else if (i_r != '0 || j_r != '0) begin
          st_nxt = S_TAIL;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_TB1: begin
        here_nxt = cost_rd;
        a_nxt    = src_rd;
        b_nxt    = tgt_rd;
        if (src_rd == tgt_rd) begin
          i_nxt  = im1;
          j_nxt  = jm1;
          st_nxt = S_TB0;
        end else begin
          st_nxt = S_TB2;
        end
      end
      S_TB2: begin
        if (im1 == '0) begin
          bnd_v = CW'(jm1);
        end else if (jm1 == '0) begin
          bnd_v = CW'(im1);
        end else begin
          bnd_v = cost_rd;
        end
        if ((CW+1)'(here_r) == (CW+1)'(bnd_v) + 1'b1) begin
          prod      = 1'b1;
          prod_kind = KIND_REPLACE;
          prod_pos  = 6'(i_r);
          prod_old  = a_r;
          prod_new  = b_r;
          i_nxt     = im1;
          j_nxt     = jm1;
          st_nxt    = S_TB0;
        end else begin
          st_nxt = S_TB3;
        end
      end
      S_TB3: begin
        bnd_v  = (im1 == '0) ? CW'(j_r) : cost_rd;
        prod   = 1'b1;
        st_nxt = S_TB0;
        if ((CW+1)'(here_r) == (CW+1)'(bnd_v) + 1'b1) begin
          prod_kind = KIND_DELETE;
          prod_pos  = 6'(im1);
          prod_old  = a_r;
          i_nxt     = im1;
        end else begin
          prod_kind = KIND_INSERT;
          prod_pos  = 6'(i_r);
          prod_new  = b_r;
          j_nxt     = jm1;
        end
      end
      S_TAIL: begin
        prod   = 1'b1;
        st_nxt = S_TB0;
        if (i_r != '0) begin
          prod_kind = KIND_DELETE;
          prod_pos  = 6'(im1);
          prod_old  = src_rd;
          i_nxt     = im1;
        end else begin
          prod_kind = KIND_INSERT;
          prod_new  = tgt_rd;
          j_nxt     = jm1;
        end
      end
      S_FIN: begin
        slen_nxt  = '0;
        tlen_nxt  = '0;
        sdone_nxt = 1'b0;
        ovf_nxt   = 1'b0;
        st_nxt    = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // One result is held back so that the last one can carry the final mark.
  always_comb begin
    cnt_nxt  = cnt_r;
    pv_nxt   = pv_r;
    pk_nxt   = pk_r;
    pp_nxt   = pp_r;
    po_nxt   = po_r;
    pn_nxt   = pn_r;
    ov_nxt   = 1'b0;
    of_nxt   = 1'b0;
    oovf_nxt = ovf_r;
    ok_nxt   = pk_r;
    opos_nxt = pp_r;
    oold_nxt = po_r;
    onew_nxt = pn_r;
    if (prod && cnt_r < KW'(RESULT_CAP)) begin
      ov_nxt  = pv_r;
      pv_nxt  = 1'b1;
      pk_nxt  = prod_kind;
      pp_nxt  = prod_pos;
      po_nxt  = prod_old;
      pn_nxt  = prod_new;
      cnt_nxt = cnt_r + 1'b1;
    end
    if (st_r == S_FIN) begin
      ov_nxt  = 1'b1;
      of_nxt  = 1'b1;
      pv_nxt  = 1'b0;
      cnt_nxt = '0;
      if (!pv_r) begin
        ok_nxt   = KIND_NONE;
        opos_nxt = '0;
        oold_nxt = '0;
        onew_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      slen_r  <= '0;
      tlen_r  <= '0;
      sdone_r <= 1'b0;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      slen_r  <= slen_nxt;
      tlen_r  <= tlen_nxt;
      sdone_r <= sdone_nxt;
      ovf_r   <= ovf_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    left_r <= left_nxt;
    diag_r <= diag_nxt;
    here_r <= here_nxt;
    dist_r <= dist_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    pk_r   <= pk_nxt;
    pp_r   <= pp_nxt;
    po_r   <= po_nxt;
    pn_r   <= pn_nxt;
    of_r   <= of_nxt;
    oovf_r <= oovf_nxt;
    ok_r   <= ok_nxt;
    opos_r <= opos_nxt;
    oold_r <= oold_nxt;
    onew_r <= onew_nxt;
  end

  // Distance stays put until the next run starts, so it is read live. The
  // overflow flag clears as the run closes, so it travels with each result.
  assign out_valid      = ov_r;
  assign out_op_kind    = ok_r;
  assign out_position   = opos_r;
  assign out_old_symbol = oold_r;
  assign out_new_symbol = onew_r;
  assign out_final_res  = of_r;
  assign out_distance   = 6'(dist_r);
  assign out_overflow   = oovf_r;

endmodule

// File: sv/edit_distance_with_traceback_top.sv
// Top level of the Levenshtein edit distance engine with traceback.
// Sequence: after the request that ends the target, the back end fills the cost table,
// then walks it back one step at a time, and the final result follows the last step.
// Throughput: a byte request is taken into a four-entry queue; while idle, the back
// end drains one request a cycle, so only reset or the fill and traceback hold busy up.
// Reset: rst_n is synchronous and active low; lengths, flags and the queue clear, the
// string and cost memories keep their contents. The receiver cannot stall the results.
module edit_distance_with_traceback_top import edt_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_mode,
  input  logic [7:0] in_symbol,
  input  logic       in_has_symbol,
  input  logic       in_last,
  output logic       out_valid,
  output logic [1:0] out_op_kind,
  output logic [5:0] out_position,
  output logic [7:0] out_old_symbol,
  output logic [7:0] out_new_symbol,
  output logic [5:0] out_distance,
  output logic       out_final_res,
  output logic       out_overflow
);

  logic  q_full, q_empty, q_push, q_pop;
  item_t q_in, q_head;

  // The front end takes each request and keeps only those that change state.
  // It holds busy high while reset is applied, so no request is taken then.
  edt_front u_front (
    .rst_n         (rst_n),
    .start         (start),
    .q_full        (q_full),
    .in_mode       (in_mode),
    .in_symbol     (in_symbol),
    .in_has_symbol (in_has_symbol),
    .in_last       (in_last),
    .busy          (busy),
    .push          (q_push),
    .push_item     (q_in)
  );

  // The queue lets requests arrive while the back end is filling the table.
  edt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // The back end stores the strings, fills the cost table and walks it back.
  edt_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (q_empty),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_op_kind    (out_op_kind),
    .out_position   (out_position),
    .out_old_symbol (out_old_symbol),
    .out_new_symbol (out_new_symbol),
    .out_distance   (out_distance),
    .out_final_res  (out_final_res),
    .out_overflow   (out_overflow)
  );

  // After the final result the block returns to idle, so no result follows at once.
  a_final_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |=> !out_valid)
    else $error("result right after the final result");

  // A result without an edit operation is only ever the single final one.
  a_none_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op_kind == KIND_NONE |-> out_final_res)
    else $error("no-operation result that is not final");

  // Inserts carry no old byte and deletes carry no new byte.
  a_insert_old: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op_kind == KIND_INSERT |-> out_old_symbol == 8'd0)
    else $error("insert with a nonzero old byte");

  a_delete_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op_kind == KIND_DELETE |-> out_new_symbol == 8'd0)
    else $error("delete with a nonzero new byte");

endmodule
